### rtl/fdsc_pkg.sv
// ----------------------------------------------------------------------------
// fdsc_pkg
// Types and codes shared by the flash download session control block.
// ----------------------------------------------------------------------------
package fdsc_pkg;

  localparam logic [2:0] MODE_ABORT    = 3'd0;
  localparam logic [2:0] MODE_PREPARE  = 3'd1;
  localparam logic [2:0] MODE_POLL     = 3'd2;
  localparam logic [2:0] MODE_BEGIN    = 3'd3;
  localparam logic [2:0] MODE_TRANSFER = 3'd4;
  localparam logic [2:0] MODE_EXIT     = 3'd5;

  localparam logic [2:0] ST_IDLE         = 3'd0;
  localparam logic [2:0] ST_PREPARING    = 3'd1;
  localparam logic [2:0] ST_READY        = 3'd2;
  localparam logic [2:0] ST_TRANSFERRING = 3'd3;
  localparam logic [2:0] ST_COMPLETE     = 3'd4;
  localparam logic [2:0] ST_FAILED       = 3'd5;

  localparam logic [3:0] RC_OK          = 4'd0;
  localparam logic [3:0] RC_SEQUENCE    = 4'd1;
  localparam logic [3:0] RC_REJECTED    = 4'd2;
  localparam logic [3:0] RC_PROGRAMMING = 4'd3;
  localparam logic [3:0] RC_RANGE       = 4'd4;
  localparam logic [3:0] RC_NOT_READY   = 4'd5;
  localparam logic [3:0] RC_LENGTH      = 4'd6;
  localparam logic [3:0] RC_WRONG_BLOCK = 4'd7;
  localparam logic [3:0] RC_SUSPENDED   = 4'd8;

  localparam logic [1:0] PREP_IDLE    = 2'd0;
  localparam logic [1:0] PREP_PENDING = 2'd1;
  localparam logic [1:0] PREP_READY   = 2'd2;
  localparam logic [1:0] PREP_FAILED  = 2'd3;

  localparam logic [1:0] ERASE_PENDING  = 2'd0;
  localparam logic [1:0] ERASE_COMPLETE = 2'd1;

  localparam logic [15:0] MAX_PAYLOAD   = 16'd4096;
  localparam logic [31:0] SLOT_SIZE_RST = 32'd262144;
  localparam logic [7:0]  COUNTER_RST   = 8'h01;

  typedef struct packed {
    logic [2:0]  mode;
    logic        inactive_slot_valid;
    logic        inactive_slot;
    logic        erase_start_ok;
    logic [1:0]  erase_status;
    logic [31:0] image_bytes;
    logic        area_ok;
    logic [7:0]  block_counter;
    logic [15:0] block_length;
    logic        flash_ok;
    logic        repeat_matches;
  } req_item_t;

  typedef struct packed {
    logic [3:0]  result_code;
    logic [1:0]  prep_status;
    logic        erase_start;
    logic        erase_reset;
    logic        access_slot;
    logic        flash_write;
    logic        flash_read;
    logic [31:0] flash_offset;
    logic [15:0] access_length;
  } rsp_item_t;

  function automatic logic [1:0] prep_of_state(input logic [2:0] st);
    logic [1:0] p;
    case (st)
      ST_PREPARING:    p = PREP_PENDING;
      ST_READY:        p = PREP_READY;
      ST_TRANSFERRING: p = PREP_READY;
      ST_COMPLETE:     p = PREP_READY;
      ST_FAILED:       p = PREP_FAILED;
      default:         p = PREP_IDLE;
    endcase
    return p;
  endfunction

endpackage

### rtl/fdsc_if.sv
// ----------------------------------------------------------------------------
// fdsc_if
// Valid/ready channels for requests and responses of the session control.
// ----------------------------------------------------------------------------
interface fdsc_req_if
  import fdsc_pkg::*;
;
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fdsc_rsp_if
  import fdsc_pkg::*;
;
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/fdsc_in_stage.sv
// ----------------------------------------------------------------------------
// fdsc_in_stage
// Input register: holds one request until the session logic takes it.
// ----------------------------------------------------------------------------
module fdsc_in_stage
  import fdsc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  fdsc_req_if.sink        in_chan,
  input  logic            advance,
  output logic            item_valid,
  output req_item_t       item
);

  logic      valid_r;
  logic      valid_nxt;
  req_item_t data_r;
  logic      load;

  assign in_chan.ready = !valid_r || advance;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_chan.data;
    end
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

### rtl/fdsc_session.sv
// ----------------------------------------------------------------------------
// fdsc_session
// Session state, slot size register and per-request checks and strobes.
// ----------------------------------------------------------------------------
module fdsc_session
  import fdsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        go,
  input  req_item_t   item,
  output rsp_item_t   rsp
);

  logic [31:0] slot_size_r;
  logic [2:0]  state_r,    state_nxt;
  logic        slot_vld_r, slot_vld_nxt;
  logic        slot_r,     slot_nxt;
  logic [7:0]  exp_cnt_r,  exp_cnt_nxt;
  logic [15:0] last_len_r, last_len_nxt;
  logic [31:0] rcvd_r,     rcvd_nxt;
  logic [31:0] img_len_r,  img_len_nxt;

  logic [3:0]  rc;
  logic        e_start, e_reset, f_write, f_read, strobe, strobe_slot;
  logic [31:0] offset;
  logic [15:0] acc_len;
  logic        is_new;
  logic [7:0]  prev_cnt;
  logic [31:0] remaining;
  logic [31:0] len_ext;

  assign is_new    = (item.block_counter == exp_cnt_r);
  assign prev_cnt  = exp_cnt_r - 8'd1;
  assign remaining = img_len_r - rcvd_r;
  assign len_ext   = {16'd0, item.block_length};

  always_comb begin
    state_nxt    = state_r;
    slot_vld_nxt = slot_vld_r;
    slot_nxt     = slot_r;
    exp_cnt_nxt  = exp_cnt_r;
    last_len_nxt = last_len_r;
    rcvd_nxt     = rcvd_r;
    img_len_nxt  = img_len_r;
    rc           = RC_OK;
    e_start      = 1'b0;
    e_reset      = 1'b0;
    f_write      = 1'b0;
    f_read       = 1'b0;
    strobe       = 1'b0;
    strobe_slot  = 1'b0;
    offset       = 32'd0;
    acc_len      = 16'd0;
    case (item.mode)
      MODE_ABORT: begin
        e_reset      = 1'b1;
        state_nxt    = ST_IDLE;
        slot_vld_nxt = 1'b0;
        slot_nxt     = 1'b0;
        exp_cnt_nxt  = COUNTER_RST;
        last_len_nxt = 16'd0;
        rcvd_nxt     = 32'd0;
        img_len_nxt  = 32'd0;
      end
      MODE_PREPARE: begin
        if (state_r != ST_IDLE && state_r != ST_FAILED) begin
          rc = RC_SEQUENCE;
        end else begin
          state_nxt    = ST_IDLE;
          slot_vld_nxt = 1'b0;
          slot_nxt     = 1'b0;
          exp_cnt_nxt  = COUNTER_RST;
          last_len_nxt = 16'd0;
          rcvd_nxt     = 32'd0;
          img_len_nxt  = 32'd0;
          if (!item.inactive_slot_valid) begin
            rc = RC_REJECTED;
          end else begin
            e_start     = 1'b1;
            strobe      = 1'b1;
            strobe_slot = item.inactive_slot;
            if (!item.erase_start_ok) begin
              rc = RC_PROGRAMMING;
            end else begin
              slot_vld_nxt = 1'b1;
              slot_nxt     = item.inactive_slot;
              state_nxt    = ST_PREPARING;
            end
          end
        end
      end
      MODE_POLL: begin
        if (state_r == ST_PREPARING && item.erase_status != ERASE_PENDING) begin
          if (item.erase_status == ERASE_COMPLETE && slot_vld_r &&
              item.inactive_slot_valid && item.inactive_slot == slot_r) begin
            state_nxt = ST_READY;
          end else begin
            state_nxt    = ST_FAILED;
            slot_vld_nxt = 1'b0;
            slot_nxt     = 1'b0;
            exp_cnt_nxt  = COUNTER_RST;
            last_len_nxt = 16'd0;
            rcvd_nxt     = 32'd0;
            img_len_nxt  = 32'd0;
          end
        end
      end
      MODE_BEGIN: begin
        if (item.image_bytes == 32'd0) begin
          rc = RC_RANGE;
        end else if (state_r == ST_FAILED) begin
          rc = RC_PROGRAMMING;
        end else if (state_r == ST_COMPLETE) begin
          rc = RC_SEQUENCE;
        end else if (state_r != ST_READY) begin
          rc = RC_NOT_READY;
        end else if (!item.area_ok || item.image_bytes > slot_size_r) begin
          rc = RC_RANGE;
        end else begin
          img_len_nxt = item.image_bytes;
          state_nxt   = ST_TRANSFERRING;
        end
      end
      MODE_TRANSFER: begin
        if (state_r != ST_TRANSFERRING) begin
          rc = RC_SEQUENCE;
        end else if (item.block_length == 16'd0 || item.block_length > MAX_PAYLOAD) begin
          rc = RC_LENGTH;
        end else if (!is_new && (last_len_r == 16'd0 || item.block_counter != prev_cnt)) begin
          rc = RC_WRONG_BLOCK;
        end else if (is_new && rcvd_r == img_len_r) begin
          rc = RC_SEQUENCE;
        end else if (is_new && len_ext > remaining) begin
          rc = RC_SUSPENDED;
        end else if (!is_new && item.block_length != last_len_r) begin
          rc = RC_WRONG_BLOCK;
        end else if (!item.area_ok) begin
          rc = RC_RANGE;
        end else begin
          strobe      = 1'b1;
          strobe_slot = slot_r;
          acc_len     = item.block_length;
          if (!is_new) begin
            f_read = 1'b1;
            offset = rcvd_r - len_ext;
            if (!item.flash_ok) begin
              rc = RC_PROGRAMMING;
            end else if (!item.repeat_matches) begin
              rc = RC_WRONG_BLOCK;
            end
          end else begin
            f_write = 1'b1;
            offset  = rcvd_r;
            if (!item.flash_ok) begin
              rc = RC_PROGRAMMING;
            end else begin
              rcvd_nxt     = rcvd_r + len_ext;
              last_len_nxt = item.block_length;
              exp_cnt_nxt  = exp_cnt_r + 8'd1;
            end
          end
        end
      end
      MODE_EXIT: begin
        if (state_r != ST_TRANSFERRING || rcvd_r != img_len_r) begin
          rc = RC_SEQUENCE;
        end else begin
          state_nxt = ST_COMPLETE;
        end
      end
      default: begin
        rc = RC_REJECTED;
      end
    endcase
  end

  always_comb begin
    rsp.result_code   = rc;
    rsp.prep_status   = prep_of_state(state_nxt);
    rsp.erase_start   = e_start;
    rsp.erase_reset   = e_reset;
    rsp.access_slot   = strobe ? strobe_slot : slot_nxt;
    rsp.flash_write   = f_write;
    rsp.flash_read    = f_read;
    rsp.flash_offset  = offset;
    rsp.access_length = acc_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_size_r <= SLOT_SIZE_RST;
    end else if (cfg_we) begin
      slot_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      slot_vld_r <= 1'b0;
      slot_r     <= 1'b0;
      exp_cnt_r  <= COUNTER_RST;
      last_len_r <= 16'd0;
      rcvd_r     <= 32'd0;
      img_len_r  <= 32'd0;
    end else if (go) begin
      state_r    <= state_nxt;
      slot_vld_r <= slot_vld_nxt;
      slot_r     <= slot_nxt;
      exp_cnt_r  <= exp_cnt_nxt;
      last_len_r <= last_len_nxt;
      rcvd_r     <= rcvd_nxt;
      img_len_r  <= img_len_nxt;
    end
  end

endmodule

### rtl/flash_download_session_control_top.sv
// ----------------------------------------------------------------------------
// flash_download_session_control_top
// Firmware download session sequencer: request in, one response out.
//
//   channel   direction  handshake      payload
//   in_chan   sink       valid/ready    req_item_t  (mode, slot, erase, block)
//   out_chan  source     valid/ready    rsp_item_t  (result code, strobes)
//   cfg_*     sink       cfg_we         slot_size, 32 bits
//
// One request per cycle while out_chan accepts responses; a response is
// presented once its request has passed the input register and the
// response register.
// Reset (synchronous, rst_n low) returns the session to idle and slot_size
// to 262144. A stalled out_chan holds its response; the input register
// keeps taking requests until both stages are full.
// ----------------------------------------------------------------------------
module flash_download_session_control_top
  import fdsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fdsc_req_if.sink    in_chan,
  fdsc_rsp_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic      item_valid;
  req_item_t item;
  rsp_item_t rsp;
  logic      out_free;
  logic      advance;
  logic      out_valid_r;
  logic      out_valid_nxt;
  rsp_item_t out_data_r;

  assign out_free = !out_valid_r || out_chan.ready;
  assign advance  = item_valid && out_free;

  fdsc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  fdsc_session u_session (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (advance),
    .item      (item),
    .rsp       (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= rsp;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flash download session control block. Requests
// go in over the valid/ready input channel under changing pacing. A local
// session predictor computes each expected response when its request
// transfers, and a monitor compares every response with the oldest one.
// ----------------------------------------------------------------------------
module tb;
  import fdsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  fdsc_req_if in_if();
  fdsc_rsp_if out_if();

  flash_download_session_control_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [31:0] sess_slot_size;
  logic [2:0]  sess_state;
  logic        sess_slot_valid;
  logic        sess_slot;
  logic [7:0]  sess_exp_cnt;
  logic [15:0] sess_last_len;
  logic [31:0] sess_rcvd;
  logic [31:0] sess_img_len;

  rsp_item_t   pending_rsp[$];
  int unsigned n_sent;
  int unsigned n_errors;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_session();
    sess_state      = ST_IDLE;
    sess_slot_valid = 1'b0;
    sess_slot       = 1'b0;
    sess_exp_cnt    = COUNTER_RST;
    sess_last_len   = '0;
    sess_rcvd       = '0;
    sess_img_len    = '0;
  endfunction

  function automatic rsp_item_t session_response(input req_item_t r);
    rsp_item_t   o;
    logic        strobe;
    logic        s_slot;
    logic        is_new;
    logic [7:0]  prev_cnt;
    logic [31:0] room;
    o        = '0;
    strobe   = 1'b0;
    s_slot   = 1'b0;
    is_new   = (r.block_counter == sess_exp_cnt);
    prev_cnt = sess_exp_cnt - 8'd1;
    room     = sess_img_len - sess_rcvd;
    o.result_code = RC_OK;
    case (r.mode)
      MODE_ABORT: begin
        o.erase_reset = 1'b1;
        clear_session();
      end
      MODE_PREPARE: begin
        if (sess_state != ST_IDLE && sess_state != ST_FAILED) begin
          o.result_code = RC_SEQUENCE;
        end else begin
          clear_session();
          if (!r.inactive_slot_valid) begin
            o.result_code = RC_REJECTED;
          end else begin
            o.erase_start = 1'b1;
            strobe        = 1'b1;
            s_slot        = r.inactive_slot;
            if (!r.erase_start_ok) begin
              o.result_code = RC_PROGRAMMING;
            end else begin
              sess_slot_valid = 1'b1;
              sess_slot       = r.inactive_slot;
              sess_state      = ST_PREPARING;
            end
          end
        end
      end
      MODE_POLL: begin
        if (sess_state == ST_PREPARING && r.erase_status != ERASE_PENDING) begin
          if (r.erase_status == ERASE_COMPLETE && sess_slot_valid &&
              r.inactive_slot_valid && r.inactive_slot == sess_slot) begin
            sess_state = ST_READY;
          end else begin
            clear_session();
            sess_state = ST_FAILED;
          end
        end
      end
      MODE_BEGIN: begin
        if (r.image_bytes == '0)             o.result_code = RC_RANGE;
        else if (sess_state == ST_FAILED)    o.result_code = RC_PROGRAMMING;
        else if (sess_state == ST_COMPLETE)  o.result_code = RC_SEQUENCE;
        else if (sess_state != ST_READY)     o.result_code = RC_NOT_READY;
        else if (!r.area_ok || r.image_bytes > sess_slot_size) o.result_code = RC_RANGE;
        else begin
          sess_img_len = r.image_bytes;
          sess_state   = ST_TRANSFERRING;
        end
      end
      MODE_TRANSFER: begin
        if (sess_state != ST_TRANSFERRING) begin
          o.result_code = RC_SEQUENCE;
        end else if (r.block_length == '0 || r.block_length > MAX_PAYLOAD) begin
          o.result_code = RC_LENGTH;
        end else if (!is_new && (sess_last_len == '0 || r.block_counter != prev_cnt)) begin
          o.result_code = RC_WRONG_BLOCK;
        end else if (is_new && sess_rcvd == sess_img_len) begin
          o.result_code = RC_SEQUENCE;
        end else if (is_new && {16'd0, r.block_length} > room) begin
          o.result_code = RC_SUSPENDED;
        end else if (!is_new && r.block_length != sess_last_len) begin
          o.result_code = RC_WRONG_BLOCK;
        end else if (!r.area_ok) begin
          o.result_code = RC_RANGE;
        end else begin
          strobe          = 1'b1;
          s_slot          = sess_slot;
          o.access_length = r.block_length;
          if (!is_new) begin
            o.flash_read   = 1'b1;
            o.flash_offset = sess_rcvd - {16'd0, r.block_length};
            if (!r.flash_ok)            o.result_code = RC_PROGRAMMING;
            else if (!r.repeat_matches) o.result_code = RC_WRONG_BLOCK;
          end else begin
            o.flash_write  = 1'b1;
            o.flash_offset = sess_rcvd;
            if (!r.flash_ok) begin
              o.result_code = RC_PROGRAMMING;
            end else begin
              sess_rcvd     = sess_rcvd + {16'd0, r.block_length};
              sess_last_len = r.block_length;
              sess_exp_cnt  = sess_exp_cnt + 8'd1;
            end
          end
        end
      end
      MODE_EXIT: begin
        if (sess_state != ST_TRANSFERRING || sess_rcvd != sess_img_len)
          o.result_code = RC_SEQUENCE;
        else
          sess_state = ST_COMPLETE;
      end
      default: begin
        o.result_code = RC_REJECTED;
      end
    endcase
    case (sess_state)
      ST_PREPARING:                         o.prep_status = PREP_PENDING;
      ST_READY, ST_TRANSFERRING, ST_COMPLETE: o.prep_status = PREP_READY;
      ST_FAILED:                            o.prep_status = PREP_FAILED;
      default:                              o.prep_status = PREP_IDLE;
    endcase
    o.access_slot = strobe ? s_slot : sess_slot;
    return o;
  endfunction

  function automatic string rsp_text(input rsp_item_t p);
    return $sformatf("rc=%0d prep=%0d es=%0b er=%0b slot=%0b fw=%0b fr=%0b off=%h len=%0d",
                     p.result_code, p.prep_status, p.erase_start, p.erase_reset,
                     p.access_slot, p.flash_write, p.flash_read, p.flash_offset,
                     p.access_length);
  endfunction

  function automatic req_item_t req_of(input logic [2:0] mode);
    logic [95:0] raw;
    req_item_t   r;
    raw    = {$urandom, $urandom, $urandom};
    r      = raw[$bits(req_item_t)-1:0];
    r.mode = mode;
    return r;
  endfunction

  function automatic req_item_t block_req(input int unsigned blk);
    req_item_t   r;
    logic [31:0] remaining;
    r         = req_of(MODE_TRANSFER);
    remaining = sess_img_len - sess_rcvd;
    r.block_counter  = sess_exp_cnt;
    r.block_length   = (remaining < blk) ? remaining[15:0] : blk[15:0];
    r.area_ok        = ($urandom_range(19) != 0);
    r.flash_ok       = ($urandom_range(19) != 0);
    r.repeat_matches = ($urandom_range(7) != 0);
    case ($urandom_range(19))
      0, 1: begin
        r.block_counter = sess_exp_cnt - 8'd1;
        r.block_length  = sess_last_len;
      end
      2: r.block_counter = 8'($urandom);
      3: r.block_length  = 16'($urandom);
      4: if (remaining < MAX_PAYLOAD) r.block_length = remaining[15:0] + 16'd1;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_rsp.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected response: %s", rsp_text(out_if.data));
      end else begin
        want = pending_rsp.pop_front();
        if (out_if.data !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch: expected %s", rsp_text(want));
            $display("          actual   %s", rsp_text(out_if.data));
          end
        end
      end
    end
  end

  task automatic send_req(input req_item_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_rsp.push_back(session_response(r));
    n_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_slot_size(input logic [31:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sess_slot_size = v;
  endtask

  task automatic set_pacing(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  task automatic open_session(input logic slot);
    req_item_t r;
    r = req_of(MODE_PREPARE);
    r.inactive_slot_valid = 1'b1;
    r.inactive_slot       = slot;
    r.erase_start_ok      = 1'b1;
    send_req(r);
    r = req_of(MODE_POLL);
    r.erase_status        = ERASE_COMPLETE;
    r.inactive_slot_valid = 1'b1;
    r.inactive_slot       = slot;
    send_req(r);
  endtask

  task automatic test_directed();
    req_item_t r;
    send_req(req_of(3'd6));
    send_req(req_of(3'd7));
    send_req(block_req(16));
    r = req_of(MODE_BEGIN); r.image_bytes = '0; send_req(r);
    r = req_of(MODE_BEGIN); r.image_bytes = 32'hFFFF_FFFF; send_req(r);
    send_req(req_of(MODE_EXIT));
    send_req(req_of(MODE_POLL));
    r = req_of(MODE_PREPARE); r.inactive_slot_valid = 1'b0; send_req(r);
    r = req_of(MODE_PREPARE); r.inactive_slot_valid = 1'b1; r.erase_start_ok = 1'b0;
    send_req(r);
    r = req_of(MODE_PREPARE); r.inactive_slot_valid = 1'b1; r.inactive_slot = 1'b1;
    r.erase_start_ok = 1'b1;
    send_req(r);
    send_req(r);
    r = req_of(MODE_POLL); r.erase_status = ERASE_PENDING; send_req(r);
    r = req_of(MODE_POLL); r.erase_status = ERASE_COMPLETE; r.inactive_slot_valid = 1'b1;
    r.inactive_slot = 1'b0;
    send_req(r);
    r = req_of(MODE_BEGIN); r.image_bytes = 32'd1; send_req(r);
    r = req_of(MODE_PREPARE); r.inactive_slot_valid = 1'b1; r.inactive_slot = 1'b0;
    r.erase_start_ok = 1'b1;
    send_req(r);
    r = req_of(MODE_POLL); r.erase_status = 2'd3; send_req(r);
    open_session(1'b1);
    r = req_of(MODE_BEGIN); r.area_ok = 1'b1; r.image_bytes = SLOT_SIZE_RST + 32'd1;
    send_req(r);
    r = req_of(MODE_BEGIN); r.area_ok = 1'b0; r.image_bytes = 32'd8192; send_req(r);
    r.area_ok = 1'b1; send_req(r);
    r = req_of(MODE_TRANSFER); r.block_counter = 8'd1; r.block_length = 16'hFFFF;
    send_req(r);
    r.block_length = MAX_PAYLOAD; r.area_ok = 1'b1; r.flash_ok = 1'b1; send_req(r);
    r.block_counter = 8'd0; r.repeat_matches = 1'b1; send_req(r);
    r.block_counter = 8'd2; send_req(r);
    r.block_counter = 8'd3; send_req(r);
    send_req(req_of(MODE_EXIT));
    send_req(req_of(MODE_ABORT));
  endtask

  task automatic random_session();
    req_item_t   r;
    logic        slot;
    int unsigned blk;
    int unsigned k;
    logic [31:0] img;
    if ($urandom_range(9) == 0) send_req(req_of(3'($urandom)));
    if ($urandom_range(3) == 0) send_req(req_of(MODE_ABORT));
    r = req_of(MODE_PREPARE);
    r.inactive_slot_valid = ($urandom_range(9) != 0);
    r.erase_start_ok      = ($urandom_range(9) != 0);
    slot = r.inactive_slot;
    send_req(r);
    repeat ($urandom_range(3)) begin
      r = req_of(MODE_POLL);
      r.erase_status = ERASE_PENDING;
      send_req(r);
    end
    r = req_of(MODE_POLL);
    r.erase_status = ($urandom_range(7) == 0) ? 2'($urandom_range(2, 3)) : ERASE_COMPLETE;
    r.inactive_slot_valid = ($urandom_range(9) != 0);
    r.inactive_slot       = ($urandom_range(9) != 0) ? slot : ~slot;
    send_req(r);
    blk = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_PAYLOAD) : $urandom_range(1, 64);
    img = blk * $urandom_range(1, 6) - $urandom_range(0, blk - 1);
    if (img > sess_slot_size && $urandom_range(4) != 0)
      img = $urandom_range(1, sess_slot_size);
    r = req_of(MODE_BEGIN);
    r.image_bytes = img;
    r.area_ok     = ($urandom_range(15) != 0);
    send_req(r);
    k = 0;
    while (sess_state == ST_TRANSFERRING && sess_rcvd != sess_img_len && k < 16) begin
      send_req(block_req(blk));
      k++;
    end
    if (sess_state == ST_TRANSFERRING && $urandom_range(2) == 0)
      send_req(block_req(blk));
    send_req(req_of(MODE_EXIT));
    if ($urandom_range(3) == 0) send_req(block_req(blk));
    if ($urandom_range(5) == 0) send_req(req_of(MODE_BEGIN));
  endtask

  task automatic test_random_sessions(input int unsigned target);
    int unsigned start;
    start = n_sent;
    while (n_sent - start < target) random_session();
  endtask

  task automatic test_counter_wrap();
    req_item_t r;
    open_session($urandom_range(1));
    r = req_of(MODE_BEGIN);
    r.area_ok     = 1'b1;
    r.image_bytes = 32'd540;
    send_req(r);
    while (sess_state == ST_TRANSFERRING && sess_rcvd != sess_img_len)
      send_req(block_req(2));
    send_req(req_of(MODE_EXIT));
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    n_sent   = 0;
    n_errors = 0;
    sess_slot_size = SLOT_SIZE_RST;
    clear_session();
    set_pacing(0, 0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    write_slot_size(32'd1);
    set_pacing(86, 0);
    test_random_sessions(200);
    write_slot_size(32'hFFFF_FFFF);
    set_pacing(0, 86);
    test_counter_wrap();
    test_random_sessions(150);
    write_slot_size($urandom_range(64, 20000));
    set_pacing(12, 12);
    test_random_sessions(250);
    write_slot_size(SLOT_SIZE_RST);
    set_pacing(0, 0);
    test_random_sessions(250);

    drain();
    repeat (8) @(posedge clk);
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fdsc_pkg.sv
rtl/fdsc_if.sv
rtl/fdsc_in_stage.sv
rtl/fdsc_session.sv
rtl/flash_download_session_control_top.sv
verif/tb.sv
